### src/smpq_pkg.sv
// Package for the sorted minimum priority queue.
// Holds the item types, operation and status codes, and the cell control struct.
// No dependencies.
`default_nettype none

package smpq_pkg;

    // Operation codes carried in the func field
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // Status codes of a result item
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Field widths fixed by the interface
    localparam int PRIO_W = 16;
    localparam int PAY_W  = 16;
    localparam int OCC_W  = 5;

    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] prio_in;
        logic [PAY_W-1:0]  payload_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [PRIO_W-1:0] prio_out;
        logic [PAY_W-1:0]  payload_out;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    // Broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic              ins_en;
        logic              pop_en;
        logic [PRIO_W-1:0] prio;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### src/smpq_cell.sv
// One storage cell of the sorted chain: a priority and a payload.
// Depends on smpq_pkg for the control struct and field widths.
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
#(
    parameter int PW = 16
) (
    input  wire              i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  wire [PW-1:0]     i_new_pay,
    input  wire              i_occupied,
    input  wire              i_left_ins,
    input  wire [PRIO_W-1:0] i_left_prio,
    input  wire [PW-1:0]     i_left_pay,
    input  wire [PRIO_W-1:0] i_right_prio,
    input  wire [PW-1:0]     i_right_pay,
    output logic             o_ins,
    output logic [PRIO_W-1:0] o_prio,
    output logic [PW-1:0]    o_pay
);

    logic [PRIO_W-1:0] r_prio;
    logic [PW-1:0]     r_pay;
    logic [PRIO_W-1:0] n_prio;
    logic [PW-1:0]     n_pay;

    // New item goes at or before this cell: empty cell, or stored prio not smaller
    always_comb begin
        o_ins = !i_occupied || (i_ctrl.prio <= r_prio);
    end

    // Insert: shift right from the left neighbor, or take the new item at the
    // boundary. Pop: shift left from the right neighbor.
    always_comb begin
        n_prio = r_prio;
        n_pay  = r_pay;
        if (i_ctrl.ins_en && o_ins) begin
            if (i_left_ins) begin
                n_prio = i_left_prio;
                n_pay  = i_left_pay;
            end else begin
                n_prio = i_ctrl.prio;
                n_pay  = i_new_pay;
            end
        end else if (i_ctrl.pop_en) begin
            n_prio = i_right_prio;
            n_pay  = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_pay  <= n_pay;
    end

    assign o_prio = r_prio;
    assign o_pay  = r_pay;

endmodule

`default_nettype wire

### src/sorted_min_priority_queue.sv
// Sorted minimum priority queue, top level: cell chain, count and result register.
// Depends on smpq_pkg and smpq_cell.
//
// Holds up to DEPTH entries in a chain of cells kept in ascending priority
// order; cell 0 is always the smallest. Every input item (insert or pop)
// produces exactly one result item in the next cycle, and a new item is taken
// every cycle unless o_in_stall is high: each cell compares the incoming
// priority with its own in parallel and shifts in one step.
// The result sits in an output register; o_in_stall is high only while that
// register holds an item and i_out_stall is high. Equal priorities leave
// last-in first-out. An insert on a full queue returns status full and leaves
// the queue unchanged; a pop on an empty queue returns status empty. There is
// no clearing pass after reset. Payloads keep their low PAYLOAD_WIDTH bits
// (at most 16).
`default_nettype none

module sorted_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (PAYLOAD_WIDTH < PAY_W) ? PAYLOAD_WIDTH : PAY_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    logic          in_acc;
    logic          full;
    logic          empty;
    t_cell_ctrl    ctrl;
    logic [PW-1:0] new_pay;

    logic [DEPTH-1:0]        occupied;
    logic [DEPTH-1:0]        ins;
    logic [PRIO_W-1:0]       cell_prio [DEPTH];
    logic [PW-1:0]           cell_pay  [DEPTH];
    logic [PAY_W-1:0]        head_pay;
    logic [CW+OCC_W-1:0]     occ_ext;

    // Handshake: take an item unless a waiting result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign new_pay = i_in_item.payload_in[PW-1:0];

    // Control broadcast to the chain
    always_comb begin
        ctrl.ins_en = in_acc && (i_in_item.func == FUNC_INSERT) && !full;
        ctrl.pop_en = in_acc && (i_in_item.func == FUNC_POP) && !empty;
        ctrl.prio   = i_in_item.prio_in;
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              left_ins;
        logic [PRIO_W-1:0] left_prio;
        logic [PW-1:0]     left_pay;
        logic [PRIO_W-1:0] right_prio;
        logic [PW-1:0]     right_pay;

        assign occupied[g] = (r_count > CW'(g));

        if (g == 0) begin : g_head
            assign left_ins  = 1'b0;
            assign left_prio = '0;
            assign left_pay  = '0;
        end else begin : g_mid
            assign left_ins  = ins[g-1];
            assign left_prio = cell_prio[g-1];
            assign left_pay  = cell_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_prio = '0;
            assign right_pay  = '0;
        end else begin : g_body
            assign right_prio = cell_prio[g+1];
            assign right_pay  = cell_pay[g+1];
        end

        smpq_cell #(
            .PW(PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_new_pay    (new_pay),
            .i_occupied   (occupied[g]),
            .i_left_ins   (left_ins),
            .i_left_prio  (left_prio),
            .i_left_pay   (left_pay),
            .i_right_prio (right_prio),
            .i_right_pay  (right_pay),
            .o_ins        (ins[g]),
            .o_prio       (cell_prio[g]),
            .o_pay        (cell_pay[g])
        );
    end

    // Head payload widened to the output field
    always_comb begin
        head_pay         = '0;
        head_pay[PW-1:0] = cell_pay[0];
    end

    // Next count and result item
    always_comb begin
        n_count = r_count;
        if (ctrl.ins_en) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.pop_en) begin
            n_count = r_count - 1'b1;
        end

        occ_ext = {{OCC_W{1'b0}}, n_count};

        n_out_item             = '0;
        n_out_item.occupancy   = occ_ext[OCC_W-1:0];
        if (i_in_item.func == FUNC_INSERT) begin
            if (full) begin
                n_out_item.status = ST_FULL;
            end
        end else begin
            if (empty) begin
                n_out_item.status = ST_EMPTY;
            end else begin
                n_out_item.prio_out    = cell_prio[0];
                n_out_item.payload_out = head_pay;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### src/smpq_checker.sv
// Port-level checks for the sorted minimum priority queue, and their bind.
// Depends on smpq_pkg and the sorted_min_priority_queue top level.
`default_nettype none

module smpq_checker
    import smpq_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_item  i_in_item,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // Input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Every accepted item gives a result in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item gave no result");

    // An empty pop reports nothing held and zero fields
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY) |->
            (o_out_item.occupancy == '0) && (o_out_item.prio_out == '0) &&
            (o_out_item.payload_out == '0))
        else $error("empty pop with nonzero fields");

    // No unused status code appears
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_OK) ||
            (o_out_item.status == ST_EMPTY) || (o_out_item.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
